// File: rtl/drm_pkg.sv
// shared types and constants for the deadlock resource manager
// no dependencies; the datapath, controller, top level and bench import this package
package drm_pkg;

    localparam int NPROC = 8;
    localparam int NRES  = 8;
    localparam int PW    = $clog2(NPROC);
    localparam int RW    = $clog2(NRES);

    localparam logic [3:0] MAX_INST   = 4'd15;
    localparam logic [3:0] PRIO_LIMIT = 4'd11;
    localparam logic [3:0] NRES_ID    = 4'(NRES);
    localparam logic [3:0] NPROC_CNT  = 4'(NPROC);

    localparam logic [2:0] MODE_REQUEST     = 3'd0;
    localparam logic [2:0] MODE_RELEASE     = 3'd1;
    localparam logic [2:0] MODE_RELEASE_ALL = 3'd2;
    localparam logic [2:0] MODE_DETECT      = 3'd3;
    localparam logic [2:0] MODE_RESOLVE     = 3'd4;

    localparam logic [1:0] CFG_RES_COUNT = 2'd0;
    localparam logic [1:0] CFG_RES_INST  = 2'd1;
    localparam logic [1:0] CFG_PRIO      = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EXEC,
        ST_RD_GRANT,
        ST_GRANT,
        ST_DFS,
        ST_SCAN,
        ST_RD_VIC,
        ST_FREE_VIC,
        ST_DONE
    } ctl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_READ_PID,
        OP_REQ,
        OP_REL,
        OP_READ_GRANT,
        OP_GRANT,
        OP_FREE,
        OP_DFS_INIT,
        OP_DFS_STEP,
        OP_SCAN_STEP,
        OP_READ_VIC,
        OP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       want_grant;
        logic       dfs_end;
        logic       dfs_found;
        logic       scan_done;
        logic       out_free;
    } dp_status_t;

    typedef struct packed {
        logic       ok;
        logic       unknown_resource;
        logic [3:0] remaining;
        logic       grant_valid;
        logic [2:0] granted_process;
        logic       deadlock_found;
        logic [7:0] cycle_mask;
        logic [2:0] victim;
    } res_t;

endpackage

// File: rtl/drm_in_if.sv
// input item channel: valid/ready plus operation fields
// no dependencies
interface drm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [2:0] process_id;
    logic [3:0] rsc_id;

    modport source (output valid, mode, process_id, rsc_id, input ready);
    modport sink (input valid, mode, process_id, rsc_id, output ready);
endinterface

// File: rtl/drm_out_if.sv
// result channel: valid/ready plus result fields
// no dependencies
interface drm_out_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic       unknown_resource;
    logic [3:0] remaining;
    logic       grant_valid;
    logic [2:0] granted_process;
    logic       deadlock_found;
    logic [7:0] cycle_mask;
    logic [2:0] victim;

    modport source (output valid, ok, unknown_resource, remaining, grant_valid,
                    granted_process, deadlock_found, cycle_mask, victim,
                    input ready);
    modport sink (input valid, ok, unknown_resource, remaining, grant_valid,
                  granted_process, deadlock_found, cycle_mask, victim,
                  output ready);
endinterface

// File: rtl/drm_cfg_if.sv
// configuration write channel: valid/ready, register index and data
// no dependencies
interface drm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/drm_datapath.sv
// datapath: configuration, resource tables, held-count memory, dfs walker,
// result register; depends on drm_pkg
module drm_datapath
    import drm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_op_t      op,
    output dp_status_t  status,
    input  logic [2:0]  in_mode,
    input  logic [2:0]  in_pid,
    input  logic [3:0]  in_rid,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output res_t        res,
    output logic        res_valid,
    input  logic        res_ready
);

    logic [3:0]  count_reg;
    logic [31:0] inst_reg;
    logic [31:0] prio_reg;

    logic [3:0]      avail_reg [NRES];
    logic [31:0]     held_mem [NPROC];
    logic [NPROC-1:0] row_valid_reg;
    logic [31:0]     row_reg;
    logic [NRES-1:0] nz_reg [NPROC];
    logic [NPROC-1:0] wait_reg;
    logic [3:0]      wres_reg [NPROC];

    logic [2:0] mode_reg;
    logic [2:0] pid_reg;
    logic [3:0] rid_reg;
    logic [2:0] tgt_reg;
    logic [2:0] gp_reg;

    logic [NPROC-1:0] visited_reg;
    logic [NPROC-1:0] onpath_reg;
    logic [2:0]       stack_reg [NPROC];
    logic [3:0]       nxt_reg [NPROC];
    logic [3:0]       depth_reg;
    logic [3:0]       root_reg;
    logic             found_reg;
    logic             end_reg;
    logic [2:0]       closing_reg;

    logic [3:0] scan_i_reg;
    logic       in_cyc_reg;
    logic [3:0] lowest_reg;
    logic [2:0] vic_reg;

    res_t res_reg;
    res_t out_reg;
    logic out_valid_reg;

    // memory port controls
    logic        mem_rd;
    logic [2:0]  mem_ra;
    logic        mem_we;
    logic [2:0]  mem_wa;
    logic [31:0] mem_wd;

    logic [3:0] count_eff;
    logic       exists;
    logic       in_range;
    logic [2:0] ridx;
    logic [3:0] held_nib;
    logic [3:0] held_inc;
    logic [3:0] avail_r;
    logic       wfound;
    logic [2:0] wp;
    logic       want_grant;
    logic [2:0] top_idx;
    logic [2:0] top_node;
    logic [3:0] top_h;
    logic       top_edge;
    logic [2:0] scan_m;
    logic       scan_ic;
    logic [3:0] scan_prio;
    logic       out_free;

    function automatic logic [31:0] set_nib(input logic [31:0] row, input logic [2:0] idx,
                                             input logic [3:0] val);
        logic [31:0] r;
        r = row;
        r[{idx, 2'b00} +: 4] = val;
        return r;
    endfunction

    // wait-for edge: waiter w blocks on a resource of which h holds an instance
    function automatic logic has_edge(input logic [2:0] w, input logic [2:0] h,
                                      input logic [NPROC-1:0] wt, input logic [3:0] wr,
                                      input logic [NRES-1:0] nzh);
        logic ok_id;
        ok_id = (wr != 4'd0) && (wr <= NRES_ID);
        return wt[w] && ok_id && nzh[3'(wr - 4'd1)];
    endfunction

    always_comb
    begin
        count_eff = (count_reg > NRES_ID) ? NRES_ID : count_reg;
        exists    = (rid_reg != 4'd0) && (rid_reg <= count_eff);
        in_range  = (rid_reg != 4'd0) && (rid_reg <= NRES_ID);
        ridx      = 3'(rid_reg - 4'd1);
        held_nib  = row_reg[{ridx, 2'b00} +: 4];
        held_inc  = (held_nib == MAX_INST) ? MAX_INST : held_nib + 4'd1;
        avail_r   = avail_reg[ridx];
        wfound    = 1'b0;
        wp        = '0;
        // lowest-numbered waiter wins
        for (int p = NPROC - 1; p >= 0; p--)
        begin
            if (wait_reg[p] && (wres_reg[p] == rid_reg))
            begin
                wfound = 1'b1;
                wp     = 3'(p);
            end
        end
        want_grant = in_range && (held_nib != 4'd0) && wfound;

        top_idx  = 3'(depth_reg - 4'd1);
        top_node = stack_reg[top_idx];
        top_h    = nxt_reg[top_idx];
        top_edge = (top_h < NPROC_CNT)
                   && has_edge(top_node, top_h[2:0], wait_reg, wres_reg[top_node],
                               nz_reg[top_h[2:0]]);

        scan_m    = stack_reg[scan_i_reg[2:0]];
        scan_ic   = in_cyc_reg || (scan_m == closing_reg);
        scan_prio = prio_reg[{scan_m, 2'b00} +: 4];

        out_free = !out_valid_reg || res_ready;
    end

    assign status.mode       = mode_reg;
    assign status.want_grant = want_grant;
    assign status.dfs_end    = end_reg;
    assign status.dfs_found  = found_reg;
    assign status.scan_done  = (scan_i_reg == depth_reg);
    assign status.out_free   = out_free;

    assign res       = out_reg;
    assign res_valid = out_valid_reg;

    always_comb
    begin
        mem_rd = 1'b0;
        mem_ra = pid_reg;
        mem_we = 1'b0;
        mem_wa = pid_reg;
        mem_wd = row_reg;
        case (op)
            OP_READ_PID:   mem_rd = 1'b1;
            OP_READ_GRANT:
            begin
                mem_rd = 1'b1;
                mem_ra = gp_reg;
            end
            OP_READ_VIC:
            begin
                mem_rd = 1'b1;
                mem_ra = vic_reg;
            end
            OP_REQ:
            begin
                mem_we = exists && (avail_r != 4'd0);
                mem_wd = set_nib(row_reg, ridx, held_inc);
            end
            OP_REL:
            begin
                mem_we = in_range && (held_nib != 4'd0);
                mem_wd = set_nib(row_reg, ridx, held_nib - 4'd1);
            end
            OP_GRANT:
            begin
                mem_we = 1'b1;
                mem_wa = gp_reg;
                mem_wd = set_nib(row_reg, ridx, held_inc);
            end
            OP_FREE:
            begin
                mem_we = 1'b1;
                mem_wa = tgt_reg;
                mem_wd = '0;
            end
            default: ;
        endcase
    end

    // held-count memory, one row of nibbles per process
    always_ff @(posedge clk)
    begin
        if (mem_we)
            held_mem[mem_wa] <= mem_wd;
        if (mem_rd)
            row_reg <= row_valid_reg[mem_ra] ? held_mem[mem_ra] : '0;
    end

    // dfs path stack and per-frame successor pointers
    always_ff @(posedge clk)
    begin
        if (op == OP_DFS_STEP)
        begin
            if (depth_reg == 4'd0)
            begin
                if (root_reg < NPROC_CNT && !visited_reg[root_reg[2:0]])
                begin
                    stack_reg[0] <= root_reg[2:0];
                    nxt_reg[0]   <= '0;
                end
            end
            else if (top_h < NPROC_CNT)
            begin
                nxt_reg[top_idx] <= top_h + 4'd1;
                if (top_edge && !visited_reg[top_h[2:0]])
                begin
                    stack_reg[depth_reg[2:0]] <= top_h[2:0];
                    nxt_reg[depth_reg[2:0]]   <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            inst_reg      <= '0;
            prio_reg      <= '0;
            row_valid_reg <= '0;
            wait_reg      <= '0;
            for (int i = 0; i < NRES; i++)
                avail_reg[i] <= '0;
            for (int i = 0; i < NPROC; i++)
            begin
                nz_reg[i]   <= '0;
                wres_reg[i] <= '0;
            end
            mode_reg      <= '0;
            pid_reg       <= '0;
            rid_reg       <= '0;
            tgt_reg       <= '0;
            gp_reg        <= '0;
            visited_reg   <= '0;
            onpath_reg    <= '0;
            depth_reg     <= '0;
            root_reg      <= '0;
            found_reg     <= 1'b0;
            end_reg       <= 1'b0;
            closing_reg   <= '0;
            scan_i_reg    <= '0;
            in_cyc_reg    <= 1'b0;
            lowest_reg    <= PRIO_LIMIT;
            vic_reg       <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                row_valid_reg[mem_wa] <= 1'b1;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RES_COUNT:
                    begin
                        count_reg <= cfg_data[3:0];
                        for (int r = 0; r < NRES; r++)
                            avail_reg[r] <= inst_reg[r*4 +: 4];
                    end
                    CFG_RES_INST:
                    begin
                        inst_reg <= cfg_data;
                        for (int r = 0; r < NRES; r++)
                            avail_reg[r] <= cfg_data[r*4 +: 4];
                    end
                    CFG_PRIO: prio_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (op == OP_LOAD_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && res_ready)
                out_valid_reg <= 1'b0;

            case (op)
                OP_LATCH:
                begin
                    mode_reg <= in_mode;
                    pid_reg  <= in_pid;
                    rid_reg  <= in_rid;
                    res_reg  <= '0;
                end
                OP_READ_PID: tgt_reg <= pid_reg;
                OP_REQ:
                begin
                    if (!exists)
                        res_reg.unknown_resource <= 1'b1;
                    else if (avail_r != 4'd0)
                    begin
                        avail_reg[ridx]       <= avail_r - 4'd1;
                        nz_reg[pid_reg][ridx] <= 1'b1;
                        res_reg.ok            <= 1'b1;
                        res_reg.remaining     <= avail_r - 4'd1;
                    end
                    else
                    begin
                        wait_reg[pid_reg] <= 1'b1;
                        wres_reg[pid_reg] <= rid_reg;
                    end
                end
                OP_REL:
                begin
                    if (in_range && held_nib != 4'd0)
                    begin
                        avail_reg[ridx]       <= (avail_r == MAX_INST) ? MAX_INST
                                                                        : avail_r + 4'd1;
                        nz_reg[pid_reg][ridx] <= (held_nib != 4'd1);
                        res_reg.ok            <= 1'b1;
                        res_reg.remaining     <= (avail_r == MAX_INST) ? MAX_INST
                                                                        : avail_r + 4'd1;
                        gp_reg                <= wp;
                    end
                    else if (exists)
                        res_reg.remaining <= avail_r;
                end
                OP_GRANT:
                begin
                    // released instance went up first, so avail is at least one here
                    avail_reg[ridx]          <= avail_r - 4'd1;
                    nz_reg[gp_reg][ridx]     <= 1'b1;
                    wait_reg[gp_reg]         <= 1'b0;
                    wres_reg[gp_reg]         <= '0;
                    res_reg.grant_valid      <= 1'b1;
                    res_reg.granted_process  <= gp_reg;
                    res_reg.remaining        <= avail_r - 4'd1;
                end
                OP_FREE:
                begin
                    for (int r = 0; r < NRES; r++)
                    begin
                        if ({1'b0, avail_reg[r]} + {1'b0, row_reg[r*4 +: 4]} > {1'b0, MAX_INST})
                            avail_reg[r] <= MAX_INST;
                        else
                            avail_reg[r] <= avail_reg[r] + row_reg[r*4 +: 4];
                    end
                    nz_reg[tgt_reg]   <= '0;
                    wait_reg[tgt_reg] <= 1'b0;
                    wres_reg[tgt_reg] <= '0;
                    res_reg.ok        <= (mode_reg == MODE_RELEASE_ALL);
                end
                OP_DFS_INIT:
                begin
                    visited_reg <= '0;
                    onpath_reg  <= '0;
                    depth_reg   <= '0;
                    root_reg    <= '0;
                    found_reg   <= 1'b0;
                    end_reg     <= 1'b0;
                end
                OP_DFS_STEP:
                begin
                    if (depth_reg == 4'd0)
                    begin
                        if (root_reg == NPROC_CNT)
                            end_reg <= 1'b1;
                        else
                        begin
                            if (!visited_reg[root_reg[2:0]])
                            begin
                                visited_reg[root_reg[2:0]] <= 1'b1;
                                onpath_reg[root_reg[2:0]]  <= 1'b1;
                                depth_reg                  <= 4'd1;
                            end
                            root_reg <= root_reg + 4'd1;
                        end
                    end
                    else if (top_h == NPROC_CNT)
                    begin
                        // all successors tried: pop the frame
                        onpath_reg[top_node] <= 1'b0;
                        depth_reg            <= depth_reg - 4'd1;
                    end
                    else if (top_edge)
                    begin
                        if (!visited_reg[top_h[2:0]])
                        begin
                            visited_reg[top_h[2:0]] <= 1'b1;
                            onpath_reg[top_h[2:0]]  <= 1'b1;
                            depth_reg               <= depth_reg + 4'd1;
                        end
                        else if (onpath_reg[top_h[2:0]])
                        begin
                            found_reg              <= 1'b1;
                            closing_reg            <= top_h[2:0];
                            vic_reg                <= top_h[2:0];
                            scan_i_reg             <= '0;
                            in_cyc_reg             <= 1'b0;
                            lowest_reg             <= PRIO_LIMIT;
                            res_reg.deadlock_found <= 1'b1;
                        end
                    end
                end
                OP_SCAN_STEP:
                begin
                    // cycle members start at the closing node on the path
                    in_cyc_reg <= scan_ic;
                    scan_i_reg <= scan_i_reg + 4'd1;
                    if (scan_ic)
                    begin
                        res_reg.cycle_mask[scan_m] <= 1'b1;
                        if (scan_prio < lowest_reg)
                        begin
                            lowest_reg <= scan_prio;
                            vic_reg    <= scan_m;
                        end
                    end
                end
                OP_READ_VIC:
                begin
                    tgt_reg        <= vic_reg;
                    res_reg.victim <= vic_reg;
                end
                OP_LOAD_OUT:
                begin
                    out_reg <= res_reg;
                end
                default: ;
            endcase
        end
    end

    a_found_end_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(found_reg && end_reg))
        else $error("dfs reported both a cycle and exhaustion");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= NPROC_CNT)
        else $error("dfs path deeper than process count");

    a_deadlock_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.deadlock_found) |-> (out_reg.cycle_mask != '0))
        else $error("deadlock reported with empty cycle");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.grant_valid) |-> out_reg.ok)
        else $error("grant without a matched release");

endmodule

// File: rtl/drm_ctrl.sv
// controller state machine sequencing datapath operations per item
// depends on drm_pkg
module drm_ctrl
    import drm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t st,
    output dp_op_t     op
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = OP_LATCH;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (st.mode == MODE_REQUEST || st.mode == MODE_RELEASE
                    || st.mode == MODE_RELEASE_ALL)
                begin
                    op         = OP_READ_PID;
                    state_next = ST_EXEC;
                end
                else if (st.mode == MODE_DETECT || st.mode == MODE_RESOLVE)
                begin
                    op         = OP_DFS_INIT;
                    state_next = ST_DFS;
                end
                else
                    state_next = ST_DONE;
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (st.mode)
                    MODE_REQUEST:     op = OP_REQ;
                    MODE_RELEASE:
                    begin
                        op = OP_REL;
                        if (st.want_grant)
                            state_next = ST_RD_GRANT;
                    end
                    MODE_RELEASE_ALL: op = OP_FREE;
                    default:          op = OP_NONE;
                endcase
            end
            ST_RD_GRANT:
            begin
                op         = OP_READ_GRANT;
                state_next = ST_GRANT;
            end
            ST_GRANT:
            begin
                op         = OP_GRANT;
                state_next = ST_DONE;
            end
            ST_DFS:
            begin
                if (st.dfs_found)
                    state_next = ST_SCAN;
                else if (st.dfs_end)
                    state_next = ST_DONE;
                else
                    op = OP_DFS_STEP;
            end
            ST_SCAN:
            begin
                if (st.scan_done)
                    state_next = (st.mode == MODE_RESOLVE) ? ST_RD_VIC : ST_DONE;
                else
                    op = OP_SCAN_STEP;
            end
            ST_RD_VIC:
            begin
                op         = OP_READ_VIC;
                state_next = ST_FREE_VIC;
            end
            ST_FREE_VIC:
            begin
                op         = OP_FREE;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    op         = OP_LOAD_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: rtl/deadlock_resource_manager.sv
// top level: resource manager with wait-for graph deadlock detection
// depends on drm_pkg, drm_in_if, drm_out_if, drm_cfg_if, drm_ctrl, drm_datapath
//
// One item at a time: a request latches the item, reads the process's row of the
// held-count memory and updates it; a release does the same and, if a waiter
// wants the freed resource, reads the waiter's row and grants it; release all
// reads the row and frees it. Detect and resolve run a depth-first walk with one
// step per root tried, per successor tested and per frame popped, then step
// through the path entries to pick out the cycle and victim; resolve then reads
// the victim's row and frees it. The result sits in an output register, so the
// next item is taken while it waits. Configuration writes are taken every cycle.
module deadlock_resource_manager
    import drm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    drm_in_if.sink    item,
    drm_out_if.source result,
    drm_cfg_if.sink   cfg
);

    dp_op_t     op;
    dp_status_t st;
    res_t       res;
    logic       in_ready;

    assign item.ready = in_ready;
    assign cfg.ready  = 1'b1;

    drm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (in_ready),
        .st       (st),
        .op       (op)
    );

    drm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .status    (st),
        .in_mode   (item.mode),
        .in_pid    (item.process_id),
        .in_rid    (item.rsc_id),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .res       (res),
        .res_valid (result.valid),
        .res_ready (result.ready)
    );

    assign result.ok               = res.ok;
    assign result.unknown_resource = res.unknown_resource;
    assign result.remaining        = res.remaining;
    assign result.grant_valid      = res.grant_valid;
    assign result.granted_process  = res.granted_process;
    assign result.deadlock_found   = res.deadlock_found;
    assign result.cycle_mask       = res.cycle_mask;
    assign result.victim           = res.victim;

endmodule

// File: verif/deadlock_resource_manager_test.sv
// self-checking bench for the deadlock resource manager: directed table then random traffic
// depends on drm_pkg, the drm_in_if, drm_out_if and drm_cfg_if interfaces and deadlock_resource_manager
module deadlock_resource_manager_test;
    import drm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    drm_in_if  item ();
    drm_out_if result ();
    drm_cfg_if cfg ();

    deadlock_resource_manager dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .result(result),
        .cfg   (cfg)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow copy of the manager state
    logic [3:0]  sh_count;
    logic [31:0] sh_inst;
    logic [31:0] sh_prio;
    logic [3:0]  avail [NRES];
    logic [3:0]  held [NPROC][NRES];
    logic        waiting [NPROC];
    logic [3:0]  wait_res [NPROC];
    logic        visited [NPROC];
    logic        on_path [NPROC];
    logic [2:0]  path [NPROC];
    int          depth;
    int          closer;

    res_t pending_results [$];
    int   errors;
    bit   stall_on;
    bit   in_burst;
    bit   hold_off;
    int   issued;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    function automatic void reload_avail();
        for (int r = 0; r < NRES; r++)
            avail[r] = sh_inst[4*r +: 4];
    endfunction

    function automatic void shadow_config(input logic [1:0] idx, input logic [31:0] val);
        if (idx == CFG_RES_COUNT)
        begin
            sh_count = val[3:0];
            reload_avail();
        end
        else if (idx == CFG_RES_INST)
        begin
            sh_inst = val;
            reload_avail();
        end
        else if (idx == CFG_PRIO)
            sh_prio = val;
    endfunction

    function automatic bit wait_edge(input int w, input int h);
        if (!waiting[w] || wait_res[w] < 1 || wait_res[w] > NRES)
            return 0;
        return held[h][wait_res[w] - 1] != 0;
    endfunction

    function automatic bit walk(input int node);
        visited[node] = 1;
        on_path[node] = 1;
        if (depth < NPROC)
        begin
            path[depth] = 3'(node);
            depth++;
        end
        for (int h = 0; h < NPROC; h++)
        begin
            if (!wait_edge(node, h))
                continue;
            if (!visited[h])
            begin
                if (walk(h))
                    return 1;
            end
            else if (on_path[h])
            begin
                closer = h;
                return 1;
            end
        end
        on_path[node] = 0;
        if (depth > 0)
            depth--;
        return 0;
    endfunction

    function automatic void free_holdings(input int p);
        for (int r = 0; r < NRES; r++)
        begin
            for (int k = 0; k < held[p][r]; k++)
                if (avail[r] < MAX_INST)
                    avail[r]++;
            held[p][r] = '0;
        end
        waiting[p] = 0;
        wait_res[p] = '0;
    endfunction

    function automatic res_t predict_op(input logic [2:0] m, input logic [2:0] pid,
                                        input logic [3:0] rid);
        res_t o;
        bit   known;
        bit   found;
        int   start;
        logic [3:0] lowest;
        o = '0;
        known = rid >= 1 && rid <= ((sh_count > NRES_ID) ? NRES_ID : sh_count);
        if (m == MODE_REQUEST)
        begin
            if (!known)
                o.unknown_resource = 1;
            else if (avail[rid - 1] != 0)
            begin
                avail[rid - 1]--;
                if (held[pid][rid - 1] < MAX_INST)
                    held[pid][rid - 1]++;
                o.ok = 1;
                o.remaining = avail[rid - 1];
            end
            else
            begin
                waiting[pid] = 1;
                wait_res[pid] = rid;
            end
        end
        else if (m == MODE_RELEASE)
        begin
            if (rid >= 1 && rid <= NRES && held[pid][rid - 1] != 0)
            begin
                held[pid][rid - 1]--;
                if (avail[rid - 1] < MAX_INST)
                    avail[rid - 1]++;
                o.ok = 1;
                for (int p = 0; p < NPROC; p++)
                begin
                    if (waiting[p] && wait_res[p] == rid && avail[rid - 1] != 0)
                    begin
                        avail[rid - 1]--;
                        if (held[p][rid - 1] < MAX_INST)
                            held[p][rid - 1]++;
                        waiting[p] = 0;
                        wait_res[p] = '0;
                        o.grant_valid = 1;
                        o.granted_process = 3'(p);
                        break;
                    end
                end
                o.remaining = avail[rid - 1];
            end
            else if (known)
                o.remaining = avail[rid - 1];
        end
        else if (m == MODE_RELEASE_ALL)
        begin
            free_holdings(pid);
            o.ok = 1;
        end
        else if (m == MODE_DETECT || m == MODE_RESOLVE)
        begin
            found = 0;
            for (int p = 0; p < NPROC; p++)
            begin
                visited[p] = 0;
                on_path[p] = 0;
            end
            depth = 0;
            for (int p = 0; p < NPROC && !found; p++)
                if (!visited[p])
                begin
                    depth = 0;
                    found = walk(p);
                end
            if (found)
            begin
                start = 0;
                lowest = PRIO_LIMIT;
                for (int i = 0; i < depth; i++)
                    if (path[i] == closer)
                    begin
                        start = i;
                        break;
                    end
                o.victim = 3'(closer);
                for (int i = start; i < depth; i++)
                begin
                    o.cycle_mask[path[i]] = 1;
                    if (sh_prio[4*path[i] +: 4] < lowest)
                    begin
                        lowest = sh_prio[4*path[i] +: 4];
                        o.victim = path[i];
                    end
                end
                o.deadlock_found = 1;
                if (m == MODE_RESOLVE)
                    free_holdings(o.victim);
                else
                    o.victim = '0;
            end
        end
        return o;
    endfunction

    // sink side: random stalls, long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            result.ready <= 1'b0;
        else if (!stall_on)
            result.ready <= 1'b1;
        else
            result.ready <= ($urandom_range(99) >= 13);
    end

    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_results.size() == 0)
                report("unexpected beat", 0, 0);
            else
            begin
                e = pending_results.pop_front();
                if (result.ok !== e.ok) report("ok", result.ok, e.ok);
                if (result.unknown_resource !== e.unknown_resource)
                    report("unknown_resource", result.unknown_resource, e.unknown_resource);
                if (result.remaining !== e.remaining)
                    report("remaining", result.remaining, e.remaining);
                if (result.grant_valid !== e.grant_valid)
                    report("grant_valid", result.grant_valid, e.grant_valid);
                if (result.granted_process !== e.granted_process)
                    report("granted_process", result.granted_process, e.granted_process);
                if (result.deadlock_found !== e.deadlock_found)
                    report("deadlock_found", result.deadlock_found, e.deadlock_found);
                if (result.cycle_mask !== e.cycle_mask)
                    report("cycle_mask", result.cycle_mask, e.cycle_mask);
                if (result.victim !== e.victim)
                    report("victim", result.victim, e.victim);
            end
        end
    end

    task automatic send_op(input logic [2:0] m, input logic [2:0] pid, input logic [3:0] rid,
                           input bit has_want, input res_t want);
        res_t p;
        cfg.valid <= 1'b0;
        while (stall_on && $urandom_range(99) < 13)
        begin
            item.valid <= 1'b0;
            @(negedge clk);
        end
        item.valid <= 1'b1;
        item.mode <= m;
        item.process_id <= pid;
        item.rsc_id <= rid;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        p = predict_op(m, pid, rid);
        if (has_want && p !== want)
            report("table row", p, want);
        pending_results.insert(pending_results.size(), has_want ? want : p);
        issued++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        shadow_config(idx, val);
        @(negedge clk);
    endtask

    task automatic drain();
        item.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic random_setup();
        logic [31:0] inst;
        inst = $urandom;
        // mostly scarce instances so waits and cycles show up
        for (int r = 0; r < NRES; r++)
            if ($urandom_range(3) != 0)
                inst[4*r +: 4] = 4'($urandom_range(2));
        write_reg(CFG_RES_COUNT, ($urandom_range(5) == 0) ? $urandom_range(15) : 3 + $urandom_range(5));
        write_reg(CFG_RES_INST, inst);
        write_reg(CFG_PRIO, $urandom);
    endtask

    typedef struct {
        logic [2:0] m;
        logic [2:0] pid;
        logic [3:0] rid;
        bit         has_want;
        res_t       want;
    } row_t;

    row_t rows [$];

    function automatic res_t mk(input logic ok, input logic unk, input logic [3:0] rem);
        res_t r;
        r = '0;
        r.ok = ok;
        r.unknown_resource = unk;
        r.remaining = rem;
        return r;
    endfunction

    function automatic void add(input logic [2:0] m, input logic [2:0] pid, input logic [3:0] rid,
                                input bit hw, input res_t w);
        row_t r;
        r.m = m; r.pid = pid; r.rid = rid; r.has_want = hw; r.want = w;
        rows.insert(rows.size(), r);
    endfunction

    initial
    begin
        logic [2:0] m;
        logic [2:0] pid;
        item.valid = 1'b0;
        item.mode = '0;
        item.process_id = '0;
        item.rsc_id = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        result.ready = 1'b0;
        errors = 0;
        issued = 0;
        stall_on = 1'b0;
        hold_off = 1'b0;
        sh_count = '0;
        sh_inst = '0;
        sh_prio = '0;
        reload_avail();
        for (int p = 0; p < NPROC; p++)
        begin
            waiting[p] = 0;
            wait_res[p] = '0;
            for (int r = 0; r < NRES; r++)
                held[p][r] = '0;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // after reset nothing exists
        add(MODE_REQUEST, 0, 1, 1, mk(0, 1, 0));
        add(MODE_RELEASE, 7, 15, 1, mk(0, 0, 0));
        add(MODE_DETECT, 0, 0, 1, mk(0, 0, 0));
        add(3'd7, 7, 15, 1, mk(0, 0, 0));
        add(MODE_RELEASE_ALL, 3, 0, 1, mk(1, 0, 0));
        foreach (rows[i])
            send_op(rows[i].m, rows[i].pid, rows[i].rid, rows[i].has_want, rows[i].want);
        drain();
        rows.delete();

        write_reg(CFG_RES_COUNT, 15);
        write_reg(CFG_RES_INST, 32'hF000_0011);
        write_reg(CFG_PRIO, 32'hFFFF_FFFF);
        add(MODE_REQUEST, 0, 0, 1, mk(0, 1, 0));
        add(MODE_REQUEST, 0, 9, 1, mk(0, 1, 0));
        add(MODE_REQUEST, 0, 1, 1, mk(1, 0, 0));
        add(MODE_REQUEST, 1, 2, 1, mk(1, 0, 0));
        add(MODE_REQUEST, 0, 8, 1, mk(1, 0, 14));
        add(MODE_REQUEST, 2, 1, 1, mk(0, 0, 0));
        add(MODE_REQUEST, 0, 2, 0, '0);
        add(MODE_REQUEST, 1, 1, 0, '0);
        add(MODE_DETECT, 0, 0, 0, '0);
        add(MODE_RESOLVE, 0, 0, 0, '0);
        add(MODE_RELEASE, 1, 2, 0, '0);
        add(MODE_RELEASE, 3, 2, 0, '0);
        add(MODE_REQUEST, 4, 1, 0, '0);
        add(MODE_REQUEST, 4, 8, 0, '0);
        add(MODE_RELEASE, 4, 8, 0, '0);
        add(MODE_REQUEST, 5, 8, 0, '0);
        add(MODE_REQUEST, 5, 8, 0, '0);
        add(MODE_DETECT, 0, 0, 0, '0);
        add(MODE_RESOLVE, 0, 0, 0, '0);
        add(3'd5, 0, 1, 1, mk(0, 0, 0));
        add(3'd6, 0, 1, 1, mk(0, 0, 0));
        foreach (rows[i])
            send_op(rows[i].m, rows[i].pid, rows[i].rid, rows[i].has_want, rows[i].want);
        drain();

        // random phases; the first runs without idling
        for (int ph = 0; ph < 13; ph++)
        begin
            stall_on = (ph != 0);
            random_setup();
            if (ph == 2)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (600) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            for (int n = 0; n < 150; n++)
            begin
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5, 6, 7: m = MODE_REQUEST;
                    8, 9, 10, 11: m = MODE_RELEASE;
                    12: m = MODE_RELEASE_ALL;
                    13, 14, 15: m = MODE_DETECT;
                    16, 17, 18: m = MODE_RESOLVE;
                    default: m = 3'($urandom_range(7));
                endcase
                pid = 3'($urandom_range(7));
                send_op(m, pid,
                        4'(($urandom_range(9) == 0) ? $urandom_range(15) : 1 + $urandom_range(7)),
                        0, '0);
            end
            drain();
        end
        stall_on = 1'b0;
        drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
